[hw/rtl/ddet_pkg.sv]
// Shared types, codes and constants of the differential drive controller.
package ddet_pkg;

  // Event timing, in ticks, and the width of the encoder pulse counters.
  localparam int unsigned SAMPLE_TICKS  = 5;
  localparam int unsigned CONTROL_TICKS = 10;
  localparam int unsigned COUNT_BITS    = 16;

  localparam int unsigned PHASE_W = 4;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned TRIM_W  = 8;

  localparam logic [TRIM_W-1:0] TRIM_STEP_RESET = 8'd5;

  // Operation codes of an input transaction.
  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_LEFT_PULSE  = 3'd1,
    OP_RIGHT_PULSE = 3'd2,
    OP_SET_MODE    = 3'd3,
    OP_SET_DUTY    = 3'd4
  } op_t;

  // Drive modes, applied at each control tick.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_RUN   = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_LEFT  = 3'd3,
    MODE_RIGHT = 3'd4,
    MODE_ON    = 3'd5,
    MODE_OFF   = 3'd6,
    MODE_STOP  = 3'd7
  } mode_t;

  // Bridge pin patterns: bit 0 left A, bit 1 left B, bit 2 right A, bit 3 right B.
  localparam logic [3:0] PINS_RUN   = 4'b0101;
  localparam logic [3:0] PINS_BACK  = 4'b1010;
  localparam logic [3:0] PINS_LEFT  = 4'b1001;
  localparam logic [3:0] PINS_RIGHT = 4'b0110;
  localparam logic [3:0] PINS_ALL   = 4'b1111;
  localparam logic [3:0] PINS_NONE  = 4'b0000;

  typedef struct packed {
    logic [2:0]        operation;
    logic [2:0]        new_mode;
    logic [DUTY_W-1:0] new_left_duty;
    logic [DUTY_W-1:0] new_right_duty;
  } in_item_t;

  typedef struct packed {
    logic               left_in_a;
    logic               left_in_b;
    logic               right_in_a;
    logic               right_in_b;
    logic [DUTY_W-1:0]  left_duty;
    logic [DUTY_W-1:0]  right_duty;
    logic               drive_enabled;
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
  } out_item_t;

  // One bit per phase value; a bit is set where the phase is a multiple of the period.
  function automatic logic [2**PHASE_W-1:0] hit_mask(input int unsigned period);
    logic [2**PHASE_W-1:0] mask;
    int unsigned k;
    mask = '0;
    for (k = 0; k < 2**PHASE_W; k = k + period) begin
      mask[k] = 1'b1;
    end
    return mask;
  endfunction

  localparam logic [2**PHASE_W-1:0] SAMPLE_HIT  = hit_mask(SAMPLE_TICKS);
  localparam logic [2**PHASE_W-1:0] CONTROL_HIT = hit_mask(CONTROL_TICKS);

  // Clamp a pulse count to the speed width.
  function automatic logic [SPEED_W-1:0] sat_speed(input logic [COUNT_BITS-1:0] count);
    logic [31:0] wide;
    wide = 32'(count);
    return (wide > 32'h0000_FFFF) ? {SPEED_W{1'b1}} : wide[SPEED_W-1:0];
  endfunction

endpackage

[hw/rtl/ddet_in_stage.sv]
// Input register of the drive controller: holds one transaction until the core takes it.
module ddet_in_stage
  import ddet_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     item_valid,
  output in_item_t item,
  input  logic     advance
);

  logic load;

  // A new transaction is taken when the register is empty or being emptied.
  assign load     = !item_valid || advance;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item <= in_item;
    end
  end

endmodule

[hw/rtl/ddet_core.sv]
// Controller state and result register: applies one held transaction per cycle while the result is not stalled.
module ddet_core
  import ddet_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  in_item_t          item,
  output logic              advance,
  input  logic [TRIM_W-1:0] trim_step,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item
);

  logic [PHASE_W-1:0]    tick_phase, tick_phase_next;
  logic [COUNT_BITS-1:0] left_count, left_count_next;
  logic [COUNT_BITS-1:0] right_count, right_count_next;
  logic [SPEED_W-1:0]    left_speed, left_speed_next;
  logic [SPEED_W-1:0]    right_speed, right_speed_next;
  mode_t                 drive_mode, drive_mode_next;
  logic [DUTY_W-1:0]     left_setting, left_setting_next;
  logic [DUTY_W-1:0]     right_setting, right_setting_next;
  logic [3:0]            bridge_pins, bridge_pins_next;
  logic [DUTY_W-1:0]     left_duty, left_duty_next;
  logic [DUTY_W-1:0]     right_duty, right_duty_next;
  logic                  running, running_next;

  logic [PHASE_W-1:0]    phase_inc;
  logic [SPEED_W:0]      speed_sum;
  logic [SPEED_W-1:0]    speed_mid;
  logic [DUTY_W-1:0]     trimmed;

  // The result register is free when empty or when its transaction leaves now.
  assign advance = item_valid && (!out_valid || !out_stall);

  // Next state for the held transaction.
  always_comb begin
    tick_phase_next    = tick_phase;
    left_count_next    = left_count;
    right_count_next   = right_count;
    left_speed_next    = left_speed;
    right_speed_next   = right_speed;
    drive_mode_next    = drive_mode;
    left_setting_next  = left_setting;
    right_setting_next = right_setting;
    bridge_pins_next   = bridge_pins;
    left_duty_next     = left_duty;
    right_duty_next    = right_duty;
    running_next       = running;
    phase_inc          = tick_phase + 1'b1;
    speed_sum          = '0;
    speed_mid          = '0;
    trimmed            = left_setting;

    case (item.operation)
      OP_TICK: begin
        tick_phase_next = phase_inc;
        // Sample period: latch speeds and restart the counters.
        if (SAMPLE_HIT[phase_inc]) begin
          left_speed_next  = sat_speed(left_count);
          right_speed_next = sat_speed(right_count);
          left_count_next  = '0;
          right_count_next = '0;
        end
        // Trim toward the floored average of the latched speeds, including any latched on this tick.
        speed_sum = {1'b0, left_speed_next} + {1'b0, right_speed_next};
        speed_mid = speed_sum[SPEED_W:1];
        if (left_speed_next > speed_mid) begin
          trimmed = left_setting - DUTY_W'(trim_step);
        end else if (left_speed_next < speed_mid) begin
          trimmed = left_setting + DUTY_W'(trim_step);
        end
        // Control period: the current mode acts on the outputs.
        if (CONTROL_HIT[phase_inc]) begin
          tick_phase_next = '0;
          unique case (drive_mode)
            MODE_IDLE: begin
            end
            MODE_RUN, MODE_BACK: begin
              left_setting_next = trimmed;
              bridge_pins_next  = (drive_mode == MODE_RUN) ? PINS_RUN : PINS_BACK;
              left_duty_next    = trimmed;
              right_duty_next   = right_setting;
            end
            MODE_LEFT, MODE_RIGHT: begin
              bridge_pins_next = (drive_mode == MODE_LEFT) ? PINS_LEFT : PINS_RIGHT;
              left_duty_next   = left_setting;
              right_duty_next  = right_setting;
            end
            MODE_ON, MODE_OFF, MODE_STOP: begin
              bridge_pins_next   = (drive_mode == MODE_ON) ? PINS_ALL : PINS_NONE;
              left_duty_next     = '0;
              right_duty_next    = '0;
              left_setting_next  = '0;
              right_setting_next = '0;
              if (drive_mode == MODE_ON) begin
                running_next = 1'b1;
              end else if (drive_mode == MODE_OFF) begin
                running_next = 1'b0;
              end else begin
                left_speed_next  = '0;
                right_speed_next = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_LEFT_PULSE: begin
        if (left_count != {COUNT_BITS{1'b1}}) begin
          left_count_next = left_count + 1'b1;
        end
      end
      OP_RIGHT_PULSE: begin
        if (right_count != {COUNT_BITS{1'b1}}) begin
          right_count_next = right_count + 1'b1;
        end
      end
      OP_SET_MODE: begin
        drive_mode_next = mode_t'(item.new_mode);
      end
      OP_SET_DUTY: begin
        left_setting_next  = item.new_left_duty;
        right_setting_next = item.new_right_duty;
      end
      default: begin
      end
    endcase
  end

  // State registers; the visible part of them forms the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      tick_phase    <= '0;
      left_count    <= '0;
      right_count   <= '0;
      left_speed    <= '0;
      right_speed   <= '0;
      drive_mode    <= MODE_IDLE;
      left_setting  <= '0;
      right_setting <= '0;
      bridge_pins   <= '0;
      left_duty     <= '0;
      right_duty    <= '0;
      running       <= 1'b0;
    end else if (advance) begin
      out_valid     <= 1'b1;
      tick_phase    <= tick_phase_next;
      left_count    <= left_count_next;
      right_count   <= right_count_next;
      left_speed    <= left_speed_next;
      right_speed   <= right_speed_next;
      drive_mode    <= drive_mode_next;
      left_setting  <= left_setting_next;
      right_setting <= right_setting_next;
      bridge_pins   <= bridge_pins_next;
      left_duty     <= left_duty_next;
      right_duty    <= right_duty_next;
      running       <= running_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result fields come straight from the state, which only moves on an advance.
  always_comb begin
    out_item.left_in_a     = bridge_pins[0];
    out_item.left_in_b     = bridge_pins[1];
    out_item.right_in_a    = bridge_pins[2];
    out_item.right_in_b    = bridge_pins[3];
    out_item.left_duty     = left_duty;
    out_item.right_duty    = right_duty;
    out_item.drive_enabled = running;
    out_item.left_speed    = left_speed;
    out_item.right_speed   = right_speed;
  end

`ifndef SYNTHESIS
  // The tick phase always restarts before reaching the control period.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    tick_phase < PHASE_W'(CONTROL_TICKS))
    else $error("tick phase beyond control period");

  // Only a tick transaction moves the tick phase.
  a_phase_on_tick: assert property (@(posedge clk) disable iff (rst)
    (advance && item.operation != OP_TICK) |=> $stable(tick_phase))
    else $error("tick phase moved without a tick");

  // The enable flag changes only when a tick transaction is applied.
  a_enable_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(advance && item.operation == OP_TICK) |=> $stable(running))
    else $error("drive enable changed outside a control tick");

  // A left pulse never lowers the left count.
  a_left_count_up: assert property (@(posedge clk) disable iff (rst)
    (advance && item.operation == OP_LEFT_PULSE) |=> left_count >= $past(left_count))
    else $error("left pulse count went down on a pulse");
`endif

endmodule

[hw/rtl/differential_drive_encoder_trim.sv]
// Top level of the two-wheel drive controller with encoder speed trim.
//
// Usage:
//   The input channel (in_valid, in_stall, in_item) carries one event per
//   transaction: a tick, a left or right encoder pulse, a mode command or a
//   duty command. The output channel (out_valid, out_stall, out_item) returns
//   exactly one transaction per input event, showing the bridge pins, duties,
//   enable flag and latched speeds after that event is applied.
//   The trim step register is written through cfg_we and cfg_data; it resets
//   to 5. The user must write it only while the block is idle (not enforced).
// Flow and throughput:
//   An event is held in the input register, then applied by the core, whose
//   result register presents its result. One event is taken per cycle while
//   the output is not stalled; the rate is set by the state update in the core.
// Reset:
//   The synchronous reset clears all counters, speeds, duties, pins and the
//   mode (idle), and empties both channel registers.
// Stalling:
//   While out_stall holds a result, the state does not move; the input
//   register takes one more event only if it is empty, after which in_stall rises.
module differential_drive_encoder_trim
  import ddet_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [TRIM_W-1:0] cfg_data
);

  logic              item_valid;
  in_item_t          item;
  logic              advance;
  logic [TRIM_W-1:0] trim_step;

  // Trim step configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_step <= TRIM_STEP_RESET;
    end else if (cfg_we) begin
      trim_step <= cfg_data;
    end
  end

  ddet_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance)
  );

  ddet_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .trim_step  (trim_step),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
